// File: rtl/stbs_pkg.sv
`timescale 1ns / 1ps

package stbs_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Record fields: time is unsigned Q24.16
	localparam int TIME_BITS = 40;
	localparam int NEURON_W  = 32;
	localparam int REC_W     = TIME_BITS + NEURON_W;

	// Request codes
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_LOWER  = 2'd2;
	localparam logic [1:0] REQ_UPPER  = 2'd3;

	// One result beat
	typedef struct packed {
		logic [IDX_W-1:0]     hit_index;
		logic [TIME_BITS-1:0] hit_time;
		logic [NEURON_W-1:0]  hit_neuron;
		logic [CNT_W-1:0]     entries_now;
		logic                 empty_flag;
		logic                 full_flag;
	} rsp_t;

endpackage

// File: rtl/stbs_req_if.sv
`timescale 1ns / 1ps

interface stbs_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      req_type;
	logic [stbs_pkg::TIME_BITS-1:0]  rec_time;
	logic [stbs_pkg::NEURON_W-1:0]   rec_neuron;
	logic [stbs_pkg::TIME_BITS-1:0]  key_time;

	modport source (output valid, req_type, rec_time, rec_neuron, key_time, input ready);
	modport sink (input valid, req_type, rec_time, rec_neuron, key_time, output ready);
endinterface

// File: rtl/stbs_rsp_if.sv
`timescale 1ns / 1ps

interface stbs_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [stbs_pkg::IDX_W-1:0]      hit_index;
	logic [stbs_pkg::TIME_BITS-1:0]  hit_time;
	logic [stbs_pkg::NEURON_W-1:0]   hit_neuron;
	logic [stbs_pkg::CNT_W-1:0]      entries_now;
	logic                            empty_flag;
	logic                            full_flag;

	modport source (output valid, hit_index, hit_time, hit_neuron, entries_now,
		empty_flag, full_flag, input ready);
	modport sink (input valid, hit_index, hit_time, hit_neuron, entries_now,
		empty_flag, full_flag, output ready);
endinterface

// File: rtl/stbs_ram.sv
`timescale 1ns / 1ps

// Single-port RAM, registered read
module stbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: rtl/stbs_ctrl.sv
`timescale 1ns / 1ps

// Request sequencer: appends into the record RAM and runs the bounded
// binary search, each probe an address state, then a compare state.
module stbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	stbs_req_if.sink        req,
	output stbs_pkg::rsp_t  res,
	output logic            res_valid,
	input  logic            res_take
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PRB_RD  = 3'd1;
	localparam logic [2:0] ST_PRB_CMP = 3'd2;
	localparam logic [2:0] ST_FET_RD  = 3'd3;
	localparam logic [2:0] ST_FET_CAP = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [2:0]                       state_q;
	logic [stbs_pkg::CNT_W-1:0]       count_q;
	logic [stbs_pkg::IDX_W-1:0]       base_q;
	logic [stbs_pkg::IDX_W-1:0]       span_q;
	logic [stbs_pkg::TIME_BITS-1:0]   key_q;
	logic                             upper_q;
	stbs_pkg::rsp_t                   res_q;

	logic                             accept;
	logic                             has_room;
	logic                             is_query;
	logic [stbs_pkg::IDX_W-1:0]       half;
	logic [stbs_pkg::IDX_W-1:0]       probe;
	logic [stbs_pkg::IDX_W-1:0]       span_adv;
	logic [stbs_pkg::IDX_W-1:0]       span_next;
	logic [stbs_pkg::TIME_BITS-1:0]   probe_time;
	logic                             advance;

	logic                             ram_we;
	logic [stbs_pkg::IDX_W-1:0]       ram_addr;
	logic [stbs_pkg::REC_W-1:0]       ram_wdata;
	logic [stbs_pkg::REC_W-1:0]       ram_rdata;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign has_room  = (count_q < stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH));
	assign is_query  = (req.req_type == stbs_pkg::REQ_LOWER) ||
		(req.req_type == stbs_pkg::REQ_UPPER);

	// Probe arithmetic
	assign half       = span_q >> 1;
	assign probe      = base_q + half;
	assign span_adv   = span_q - half - stbs_pkg::IDX_W'(1);
	assign probe_time = ram_rdata[stbs_pkg::NEURON_W +: stbs_pkg::TIME_BITS];
	assign advance    = upper_q ? (probe_time <= key_q) : (probe_time < key_q);
	assign span_next  = advance ? span_adv : half;

	// RAM port: append writes in idle, probe and fetch reads otherwise
	always_comb begin
		ram_we    = accept && (req.req_type == stbs_pkg::REQ_APPEND) && has_room;
		ram_wdata = {req.rec_time, req.rec_neuron};
		case (state_q)
			ST_PRB_RD: ram_addr = probe;
			ST_FET_RD: ram_addr = base_q;
			default:   ram_addr = count_q[stbs_pkg::IDX_W-1:0];
		endcase
	end

	stbs_ram #(
		.WIDTH (stbs_pkg::REC_W),
		.DEPTH (stbs_pkg::TABLE_DEPTH)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Sequencer state and record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							stbs_pkg::REQ_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							stbs_pkg::REQ_APPEND: begin
								if (has_room) begin
									count_q <= count_q + stbs_pkg::CNT_W'(1);
								end
								state_q <= ST_DONE;
							end
							default: begin
								if (count_q == '0) begin
									state_q <= ST_DONE;
								end else if (count_q == stbs_pkg::CNT_W'(1)) begin
									state_q <= ST_FET_RD;
								end else begin
									state_q <= ST_PRB_RD;
								end
							end
						endcase
					end
				end
				ST_PRB_RD:  state_q <= ST_PRB_CMP;
				ST_PRB_CMP: state_q <= (span_next == '0) ? ST_FET_RD : ST_PRB_RD;
				ST_FET_RD:  state_q <= ST_FET_CAP;
				ST_FET_CAP: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search window and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= '0;
			span_q  <= stbs_pkg::IDX_W'(count_q - stbs_pkg::CNT_W'(1));
			key_q   <= req.key_time;
			upper_q <= (req.req_type == stbs_pkg::REQ_UPPER);
			res_q.hit_index  <= '0;
			res_q.hit_time   <= '0;
			res_q.hit_neuron <= '0;
			res_q.empty_flag <= is_query && (count_q == '0);
			res_q.full_flag  <= (req.req_type == stbs_pkg::REQ_APPEND) && !has_room;
			case (req.req_type)
				stbs_pkg::REQ_CLEAR:  res_q.entries_now <= '0;
				stbs_pkg::REQ_APPEND: res_q.entries_now <= has_room ?
					count_q + stbs_pkg::CNT_W'(1) : count_q;
				default:              res_q.entries_now <= count_q;
			endcase
		end else if (state_q == ST_PRB_CMP) begin
			if (advance) begin
				base_q <= probe + stbs_pkg::IDX_W'(1);
			end
			span_q <= span_next;
		end else if (state_q == ST_FET_CAP) begin
			res_q.hit_index  <= base_q;
			res_q.hit_time   <= probe_time;
			res_q.hit_neuron <= ram_rdata[stbs_pkg::NEURON_W-1:0];
		end
	end

	assign res       = res_q;
	assign res_valid = (state_q == ST_DONE);

endmodule

// File: rtl/sorted_time_bound_search.sv
`timescale 1ns / 1ps

// Sorted event-time table with lower/upper-bound search.
// req channel: one beat per request (clear, append, lower-bound query,
// upper-bound query); rsp channel: exactly one beat per request, in order.
// Appends must come in nondecreasing time for the search to be meaningful.
// From request beat to result in the output register:
//   clear/append: straight to the done state, then the hand-off.
//   query: each probe an address state, then a compare state, with
//   ceil(log2(count)) probes at most (12 for a full table), then the
//   final record fetch (read, capture) and hand-off. The single record
//   RAM port sets the probe rate.
// One request is in work at a time; the next request beat is taken as soon
// as the previous result has moved to the output register.
// Reset clears the record count; RAM contents stay undefined, and no
// clearing pass is run since only written entries are ever used in a result.
// When the receiver stalls, the result waits in the output register; the
// next request is still taken and worked, then held until the register frees.
module sorted_time_bound_search (
	input  logic        clk,
	input  logic        arst_n,
	stbs_req_if.sink    req,
	stbs_rsp_if.source  rsp
);

	stbs_pkg::rsp_t res;
	stbs_pkg::rsp_t out_q;
	logic           res_valid;
	logic           res_take;
	logic           out_valid_q;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take)
	);

	// Output register
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit_index   = out_q.hit_index;
	assign rsp.hit_time    = out_q.hit_time;
	assign rsp.hit_neuron  = out_q.hit_neuron;
	assign rsp.entries_now = out_q.entries_now;
	assign rsp.empty_flag  = out_q.empty_flag;
	assign rsp.full_flag   = out_q.full_flag;

	// Checks
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while previous one still in work");

	a_index_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.entries_now != '0) |-> rsp.hit_index < rsp.entries_now)
		else $error("result index beyond record count");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.empty_flag |->
			(rsp.entries_now == '0) && (rsp.hit_index == '0) && !rsp.full_flag)
		else $error("empty result with records or fields set");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.full_flag |->
			rsp.entries_now == stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH))
		else $error("append dropped while table not full");

endmodule
